### src/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// No dependencies; bpa_word_update, the top level, the checker and the testbench import it.
package bpa_pkg;

  localparam int CNT_W  = 13;  // width of page counts on the ports
  localparam int ADDR_W = 64;  // width of byte addresses

  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_PAGES = 2'd1;
  localparam logic [1:0] CFG_RESV = 2'd2;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_INVALID  = 3'd1,
    STS_NOFIT    = 3'd2,
    STS_PAGE_BAD = 3'd3,
    STS_SKIPPED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_SET  = 2'd1,
    OP_CLR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_SCAN,
    S_SWEEP,
    S_FINISH
  } fsm_t;

endpackage

### src/bpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bpa_run_finder.sv
// Per-word first-fit step: extends the free run carried in from lower words.
// Depends on nothing but its parameters.
module bpa_run_finder #(
  parameter int W  = 32,
  parameter int CW = 13
) (
  input  logic [W-1:0]  used_word,
  input  logic [CW:0]   page_base,
  input  logic [CW-1:0] active_pages,
  input  logic [CW-1:0] need,
  input  logic [CW-1:0] run_in,
  output logic          hit,
  output logic [CW-1:0] hit_start,
  output logic [CW-1:0] run_out
);

  logic [W-1:0]  occ;
  logic [CW+1:0] len [W];
  logic [CW+1:0] start_sum;

  always_comb begin
    // Pages beyond the managed range count as used.
    for (int b = 0; b < W; b++) begin
      occ[b] = used_word[b] |
               (({1'b0, page_base} + (CW+2)'(b)) >= (CW+2)'(active_pages));
    end
    // Free run length ending at each bit: from the nearest used bit below it,
    // or through the run carried in when the word is free up to that bit.
    for (int b = 0; b < W; b++) begin
      len[b] = (CW+2)'(run_in) + (CW+2)'(b + 1);
      for (int k = 0; k < W; k++) begin
        if (k <= b && occ[k]) begin
          len[b] = (CW+2)'(b - k);
        end
      end
    end
    hit = 1'b0;
    start_sum = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (len[b] >= (CW+2)'(need)) begin
        hit = 1'b1;
        start_sum = {1'b0, page_base} + (CW+2)'(b + 1) - (CW+2)'(need);
      end
    end
    hit_start = start_sum[CW-1:0];
    run_out = len[W-1][CW-1:0];
  end

endmodule

### src/bpa_word_update.sv
// Read-modify-write of one map word: set, clear or rebuild a page range.
// Depends on bpa_pkg for the operation type.
module bpa_word_update
  import bpa_pkg::*;
#(
  parameter int W  = 32,
  parameter int CW = 13,
  parameter int BW = 5
) (
  input  op_t           op,
  input  logic [W-1:0]  old_word,
  input  logic [CW:0]   page_base,
  input  logic [CW-1:0] lo,
  input  logic [CW-1:0] hi,
  output logic [W-1:0]  new_word,
  output logic [BW:0]   flips
);

  logic [W-1:0]  mask;
  logic [W-1:0]  diff;
  logic [CW+1:0] page;

  always_comb begin
    for (int b = 0; b < W; b++) begin
      page = {1'b0, page_base} + (CW+2)'(b);
      mask[b] = (page >= (CW+2)'(lo)) && (page < (CW+2)'(hi));
    end
    case (op)
      OP_INIT: begin
        new_word = mask;
        diff = old_word ^ mask;
      end
      OP_SET: begin
        new_word = old_word | mask;
        diff = mask & ~old_word;
      end
      OP_CLR: begin
        new_word = old_word & ~mask;
        diff = old_word & mask;
      end
      default: begin
        new_word = old_word;
        diff = '0;
      end
    endcase
    flips = (BW+1)'($countones(diff));
  end

endmodule

### src/bitmap_page_allocator.sv
// Bitmap page-frame allocator, first fit, top level.
// Depends on bpa_pkg, bpa_ram, bpa_run_finder and bpa_word_update.
//
//   channel   direction  handshake            payload
//   in_       request    in_valid/in_ready    command, address, count
//   out_      result     out_valid/out_ready  status, result_address, pages_changed,
//                                             free_total, used_total
//   cfg_      write      cfg_we               cfg_index, cfg_wdata
//
// The used map sits in one RAM of MAX_PAGES/MAP_WORD_BITS words and is walked one
// word per cycle by a read-modify-write pipeline with a registered RAM read.
// Init walks every map word, free and mark the words of their run, and allocate
// scans the words up to the fit and then sweeps the words of the run.
// After reset a clearing pass writes zero to every map word before the first request.
// One request is in flight; a finished result waits in the output register
// while the next request is taken.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES     = 4096,
  parameter int PAGE_BYTES    = 4096,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [CNT_W-1:0]  in_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [ADDR_W-1:0] out_result_address,
  output logic [CNT_W-1:0]  out_pages_changed,
  output logic [CNT_W-1:0]  out_free_total,
  output logic [CNT_W-1:0]  out_used_total,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW = $clog2(MAP_WORD_BITS);
  localparam int SH = $clog2(PAGE_BYTES);
  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam int CW = (PW > CNT_W) ? PW : CNT_W;
  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);
  localparam logic [CW-1:0] MAXP = CW'(MAX_PAGES);

  fsm_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  op_t  op_r, op_nxt;
  status_t status_r, status_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt, s_r, s_nxt, base_r, base_nxt;
  logic [CNT_W-1:0]  pcount_r, pcount_nxt, resv_r, resv_nxt;
  logic [CW-1:0] count_r, count_nxt, active_r, active_nxt;
  logic [CW-1:0] free_r, free_nxt, used_r, used_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, run_r, run_nxt, cnt_r, cnt_nxt;
  logic [WW-1:0] last_r, last_nxt, rw_r, rw_nxt;
  logic [WW:0]   iw_r, iw_nxt;
  logic          rv_r, rv_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]  out_chg_r, out_chg_nxt, out_free_r, out_free_nxt;
  logic [CNT_W-1:0]  out_used_r, out_used_nxt;

  logic                     ram_we, ram_re;
  logic [WW-1:0]            ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata, upd_word;
  logic [BW:0]              upd_flips;
  logic [CW:0]              page_base;
  logic                     fit_hit;
  logic [CW-1:0]            fit_start, fit_run;
  logic                     out_load;
  logic [CW-1:0]            ap, rr, lo_c, hi_c;
  logic [CW:0]              end_c;
  logic                     s_in;

  assign page_base = (CW+1)'(rw_r) << BW;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  bpa_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(iw_r[WW-1:0]), .rdata(ram_rdata)
  );

  bpa_run_finder #(.W(MAP_WORD_BITS), .CW(CW)) u_finder (
    .used_word(ram_rdata), .page_base(page_base), .active_pages(active_r),
    .need(count_r), .run_in(run_r), .hit(fit_hit), .hit_start(fit_start),
    .run_out(fit_run)
  );

  bpa_word_update #(.W(MAP_WORD_BITS), .CW(CW), .BW(BW)) u_update (
    .op(op_r), .old_word(ram_rdata), .page_base(page_base), .lo(lo_r),
    .hi(hi_r), .new_word(upd_word), .flips(upd_flips)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (iw_r[WW-1:0] == LAST_WORD) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: state_nxt = S_CHECK;
      S_CHECK: begin
        case (cmd_r)
          CMD_INIT: state_nxt = S_SWEEP;
          CMD_ALLOC: begin
            if (count_r == '0 || count_r > free_r || count_r > active_r) begin
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          CMD_FREE: begin
            if (addr_r == '0 || count_r == '0 || !s_in) state_nxt = S_FINISH;
            else state_nxt = S_SWEEP;
          end
          default: begin
            if (addr_r == '0 || !s_in) state_nxt = S_FINISH;
            else state_nxt = S_SWEEP;
          end
        endcase
      end
      S_SCAN: begin
        if (rv_r && fit_hit) state_nxt = S_SWEEP;
        else if (rv_r && rw_r == last_r) state_nxt = S_FINISH;
      end
      S_SWEEP: begin
        if (rv_r && rw_r == last_r) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    s_in = s_r < ADDR_W'(active_r);
    ap = (CW'(pcount_r) > MAXP) ? MAXP : CW'(pcount_r);
    rr = (CW'(resv_r) > ap) ? ap : CW'(resv_r);
    end_c = (CW+1)'(s_r[CW-1:0]) + (CW+1)'(count_r);
    lo_c = s_r[CW-1:0];
    hi_c = (end_c > (CW+1)'(active_r)) ? active_r : end_c[CW-1:0];
  end

  // Datapath and outputs.
  always_comb begin
    cmd_nxt = cmd_r;
    addr_nxt = addr_r;
    count_nxt = count_r;
    s_nxt = s_r;
    op_nxt = op_r;
    status_nxt = status_r;
    base_nxt = base_r;
    pcount_nxt = pcount_r;
    resv_nxt = resv_r;
    active_nxt = active_r;
    free_nxt = free_r;
    used_nxt = used_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    last_nxt = last_r;
    iw_nxt = iw_r;
    rw_nxt = iw_r[WW-1:0];
    rv_nxt = 1'b0;
    ram_we = 1'b0;
    ram_waddr = rw_r;
    ram_wdata = upd_word;
    ram_re = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt = out_addr_r;
    out_chg_nxt = out_chg_r;
    out_free_nxt = out_free_r;
    out_used_nxt = out_used_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  base_nxt = cfg_wdata;
        CFG_PAGES: pcount_nxt = cfg_wdata[CNT_W-1:0];
        CFG_RESV:  resv_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = iw_r[WW-1:0];
        ram_wdata = '0;
        iw_nxt = iw_r + 1'b1;
      end
      S_IDLE: begin
        cmd_nxt = cmd_t'(in_command);
        addr_nxt = in_address;
        count_nxt = CW'(in_count);
      end
      S_DECODE: begin
        s_nxt = (addr_r - base_r) >> SH;
      end
      S_CHECK: begin
        status_nxt = STS_OK;
        cnt_nxt = '0;
        run_nxt = '0;
        iw_nxt = '0;
        case (cmd_r)
          CMD_INIT: begin
            active_nxt = ap;
            op_nxt = OP_INIT;
            lo_nxt = '0;
            hi_nxt = rr;
            last_nxt = LAST_WORD;
          end
          CMD_ALLOC: begin
            op_nxt = OP_SET;
            last_nxt = WW'((active_r - 1'b1) >> BW);
            if (count_r == '0 || count_r > free_r || count_r > active_r) begin
              status_nxt = STS_INVALID;
            end
          end
          CMD_FREE: begin
            op_nxt = OP_CLR;
            lo_nxt = lo_c;
            hi_nxt = hi_c;
            iw_nxt = (WW+1)'(lo_c >> BW);
            last_nxt = WW'((hi_c - 1'b1) >> BW);
            if (addr_r == '0 || count_r == '0) status_nxt = STS_INVALID;
          end
          default: begin
            op_nxt = OP_SET;
            lo_nxt = lo_c;
            hi_nxt = lo_c + 1'b1;
            iw_nxt = (WW+1)'(lo_c >> BW);
            last_nxt = WW'(lo_c >> BW);
            if (addr_r == '0) status_nxt = STS_INVALID;
            else if (!s_in) status_nxt = STS_PAGE_BAD;
          end
        endcase
      end
      S_SCAN: begin
        ram_re = (iw_r <= {1'b0, last_r});
        iw_nxt = iw_r + 1'b1;
        rv_nxt = ram_re;
        if (rv_r) begin
          run_nxt = fit_run;
          if (fit_hit) begin
            lo_nxt = fit_start;
            hi_nxt = fit_start + count_r;
            iw_nxt = (WW+1)'(fit_start >> BW);
            last_nxt = WW'((fit_start + count_r - 1'b1) >> BW);
            rv_nxt = 1'b0;
          end else if (rw_r == last_r) begin
            status_nxt = STS_NOFIT;
          end
        end
      end
      S_SWEEP: begin
        ram_re = (iw_r <= {1'b0, last_r});
        iw_nxt = iw_r + 1'b1;
        rv_nxt = ram_re;
        if (rv_r) begin
          ram_we = 1'b1;
          cnt_nxt = cnt_r + CW'(upd_flips);
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_addr_nxt = '0;
          out_chg_nxt = cnt_r[CNT_W-1:0];
          case (cmd_r)
            CMD_INIT: begin
              free_nxt = active_r - hi_r;
              used_nxt = hi_r;
            end
            CMD_ALLOC: begin
              if (status_r == STS_OK) begin
                free_nxt = free_r - count_r;
                used_nxt = used_r + count_r;
                out_addr_nxt = base_r + (ADDR_W'(lo_r) << SH);
              end
            end
            CMD_FREE: begin
              if (status_r == STS_OK) begin
                free_nxt = free_r + cnt_r;
                used_nxt = used_r - cnt_r;
                if (cnt_r != count_r) out_status_nxt = STS_SKIPPED;
              end
            end
            default: begin
              if (status_r == STS_OK) begin
                if (cnt_r == '0) begin
                  out_status_nxt = STS_PAGE_BAD;
                end else begin
                  free_nxt = free_r - 1'b1;
                  used_nxt = used_r + 1'b1;
                end
              end
            end
          endcase
          out_free_nxt = free_nxt[CNT_W-1:0];
          out_used_nxt = used_nxt[CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      iw_r <= '0;
      rv_r <= 1'b0;
      out_valid_r <= 1'b0;
      base_r <= '0;
      pcount_r <= CNT_W'(4096);
      resv_r <= '0;
      active_r <= MAXP;
      free_r <= MAXP;
      used_r <= '0;
    end else begin
      state_r <= state_nxt;
      iw_r <= iw_nxt;
      rv_r <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      base_r <= base_nxt;
      pcount_r <= pcount_nxt;
      resv_r <= resv_nxt;
      active_r <= active_nxt;
      free_r <= free_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    addr_r <= addr_nxt;
    count_r <= count_nxt;
    s_r <= s_nxt;
    op_r <= op_nxt;
    status_r <= status_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    run_r <= run_nxt;
    cnt_r <= cnt_nxt;
    last_r <= last_nxt;
    rw_r <= rw_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r <= out_addr_nxt;
    out_chg_r <= out_chg_nxt;
    out_free_r <= out_free_nxt;
    out_used_r <= out_used_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_pages_changed = out_chg_r;
  assign out_free_total = out_free_r;
  assign out_used_total = out_used_r;

endmodule

### src/bpa_checker.sv
// Port-level checks of the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg for the status codes.
module bpa_checker
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = 4096
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_status,
  input logic [ADDR_W-1:0] out_result_address,
  input logic [CNT_W-1:0]  out_pages_changed,
  input logic [CNT_W-1:0]  out_free_total,
  input logic [CNT_W-1:0]  out_used_total
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_address) &&
    $stable(out_status))
    else $error("result changed while stalled");

  // Free and used pages never add up to more than MAX_PAGES.
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_free_total} + {1'b0, out_used_total}) <=
    (CNT_W+1)'(MAX_PAGES))
    else $error("free and used totals exceed the map");

  // A failed request changes no page.
  a_fail_nochange: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_INVALID || out_status == STS_NOFIT ||
    out_status == STS_PAGE_BAD) |-> out_pages_changed == '0)
    else $error("failed request reported changed pages");

  // Only a successful request returns an address.
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_address != '0 |-> out_status == STS_OK)
    else $error("address returned with an error status");

endmodule

bind bitmap_page_allocator bpa_checker #(.MAX_PAGES(MAX_PAGES)) u_bpa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_status(out_status),
  .out_result_address(out_result_address),
  .out_pages_changed(out_pages_changed),
  .out_free_total(out_free_total),
  .out_used_total(out_used_total)
);

### tb/bpa_checker.sv
`timescale 1ns / 100ps
// Checker for the bitmap page allocator: watches the request, result and register ports,
// predicts each result from its own copy of the used map and compares it. Uses bpa_pkg.
module bpa_scoreboard
  import bpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [CNT_W-1:0]  in_count,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_status,
  input  logic [ADDR_W-1:0] out_result_address,
  input  logic [CNT_W-1:0]  out_pages_changed,
  input  logic [CNT_W-1:0]  out_free_total,
  input  logic [CNT_W-1:0]  out_used_total,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output int                pending,
  output int                failures,
  output int                results_seen
);

  localparam int MAP_PAGES  = 4096;
  localparam int PAGE_BYTES = 4096;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] run_address;
    logic [CNT_W-1:0]  flipped;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W-1:0]  taken;
  } outcome_t;

  outcome_t expected_outcomes[$];

  logic [MAP_PAGES-1:0] page_used;
  int unsigned avail_cnt, taken_cnt, live_pages;
  logic [ADDR_W-1:0] reg_base;
  int unsigned reg_pages, reg_resv;

  function automatic outcome_t execute(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                       logic [CNT_W-1:0] cnt);
    outcome_t o;
    logic [ADDR_W-1:0] first;
    int unsigned resv, run, at, changed, n;
    bit found;
    o = '0;
    o.status = STS_OK;
    changed = 0;
    n = cnt;
    first = (addr - reg_base) / PAGE_BYTES;
    case (cmd)
      CMD_INIT: begin
        live_pages = (reg_pages > MAP_PAGES) ? MAP_PAGES : reg_pages;
        resv = (reg_resv > live_pages) ? live_pages : reg_resv;
        for (int i = 0; i < MAP_PAGES; i++) begin
          if (page_used[i] != (i < resv)) begin
            changed++;
            page_used[i] = (i < resv);
          end
        end
        avail_cnt = live_pages - resv;
        taken_cnt = resv;
      end
      CMD_ALLOC: begin
        if (n == 0 || n > avail_cnt || n > live_pages) begin
          o.status = STS_INVALID;
        end else begin
          run = 0;
          found = 0;
          at = 0;
          for (int i = 0; i < live_pages && !found; i++) begin
            run = page_used[i] ? 0 : run + 1;
            if (run == n) begin
              found = 1;
              at = i - n + 1;
            end
          end
          if (!found) begin
            o.status = STS_NOFIT;
          end else begin
            for (int j = 0; j < n; j++) page_used[at + j] = 1'b1;
            avail_cnt -= n;
            taken_cnt += n;
            changed = n;
            o.run_address = reg_base + ADDR_W'(at) * PAGE_BYTES;
          end
        end
      end
      CMD_FREE: begin
        if (addr == '0 || n == 0) begin
          o.status = STS_INVALID;
        end else begin
          if (first < live_pages) begin
            for (int i = 0; i < n && i < live_pages - first; i++) begin
              if (page_used[first + i]) begin
                page_used[first + i] = 1'b0;
                changed++;
              end
            end
          end
          avail_cnt += changed;
          taken_cnt -= changed;
          if (changed != n) o.status = STS_SKIPPED;
        end
      end
      default: begin
        if (addr == '0) begin
          o.status = STS_INVALID;
        end else if (first >= live_pages || page_used[first]) begin
          o.status = STS_PAGE_BAD;
        end else begin
          page_used[first] = 1'b1;
          avail_cnt--;
          taken_cnt++;
          changed = 1;
        end
      end
    endcase
    o.flipped = changed[CNT_W-1:0];
    o.avail = avail_cnt[CNT_W-1:0];
    o.taken = taken_cnt[CNT_W-1:0];
    return o;
  endfunction

  assign pending = expected_outcomes.size();

  always @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      page_used = '0;
      avail_cnt = MAP_PAGES;
      taken_cnt = 0;
      live_pages = MAP_PAGES;
      reg_base = '0;
      reg_pages = MAP_PAGES;
      reg_resv = 0;
      expected_outcomes.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:  reg_base = cfg_wdata;
          CFG_PAGES: reg_pages = cfg_wdata[CNT_W-1:0];
          CFG_RESV:  reg_resv = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_outcomes.push_back(execute(cmd_t'(in_command), in_address, in_count));
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          e = expected_outcomes.pop_front();
          if (out_status != e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            failures++;
          end
          if (out_result_address != e.run_address) begin
            $error("result_address: expected %h, got %h", e.run_address, out_result_address);
            failures++;
          end
          if (out_pages_changed != e.flipped) begin
            $error("pages_changed: expected %0d, got %0d", e.flipped, out_pages_changed);
            failures++;
          end
          if (out_free_total != e.avail) begin
            $error("free_total: expected %0d, got %0d", e.avail, out_free_total);
            failures++;
          end
          if (out_used_total != e.taken) begin
            $error("used_total: expected %0d, got %0d", e.taken, out_used_total);
            failures++;
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request stimulus, result-side stalls
// and the verdict. Depends on bpa_pkg, bitmap_page_allocator and bpa_scoreboard.
module testbench;
  import bpa_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid, in_ready;
  logic [1:0]        in_command;
  logic [ADDR_W-1:0] in_address;
  logic [CNT_W-1:0]  in_count;
  logic              out_valid, out_ready;
  logic [2:0]        out_status;
  logic [ADDR_W-1:0] out_result_address;
  logic [CNT_W-1:0]  out_pages_changed, out_free_total, out_used_total;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;
  int                pending, failures, results_seen;

  // Local view of the settings, only to aim addresses and counts at the managed pages.
  logic [ADDR_W-1:0] cur_base;
  int unsigned       cur_pages;
  int                sent[4];
  int                settings_done;
  int                burst_left;

  bitmap_page_allocator u_top (.*);
  bpa_scoreboard u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: changing stall pattern, plus two long hold-offs that back the block up.
  initial begin
    int unsigned cyc;
    int unsigned mode;
    cyc = 0;
    mode = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 4000 || cyc == 60000) begin
        out_ready <= 1'b0;
        repeat (900) @(posedge clk);
        cyc += 900;
      end
      if (cyc % 300 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] cnt);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_count <= cnt;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent[cmd]++;
  endtask

  task automatic pause(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    pause(1);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Registers are written only with nothing in flight; pages and reserve act at init, the base at once.
  task automatic set_registers(logic [ADDR_W-1:0] base, logic [CNT_W-1:0] pages,
                               logic [CNT_W-1:0] resv);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_PAGES;
    cfg_wdata <= ADDR_W'(pages);
    @(posedge clk);
    cfg_index <= CFG_RESV;
    cfg_wdata <= ADDR_W'(resv);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_base = base;
    cur_pages = (pages > 4096) ? 4096 : pages;
    settings_done++;
    send(CMD_INIT, ADDR_W'($urandom), CNT_W'($urandom));
  endtask

  function automatic logic [ADDR_W-1:0] addr_of_page(int unsigned page);
    return cur_base + ADDR_W'(page) * 4096;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] low;
    low = $urandom_range(0, 1) ? '0 : ADDR_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 19))
      0: return '0;
      1: return {$urandom, $urandom};
      2: return cur_base - ADDR_W'($urandom_range(1, 8)) * 4096;
      default: return addr_of_page($urandom_range(0, cur_pages + 2)) + low;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 29))
      0: return '0;
      1: return CNT_W'($urandom);
      2, 3: return CNT_W'($urandom_range(1, cur_pages + 1));
      default: return CNT_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic random_requests(int n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) send(CMD_INIT, {$urandom, $urandom}, CNT_W'($urandom));
      else if (pick < 40) send(CMD_ALLOC, {$urandom, $urandom}, pick_count());
      else if (pick < 78) send(CMD_FREE, pick_address(), pick_count());
      else send(CMD_MARK, pick_address(), CNT_W'($urandom));
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        pause($urandom_range(1, 20));
        burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_INIT;
    in_address <= '0;
    in_count <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BASE;
    cfg_wdata <= '0;
    cur_base = '0;
    cur_pages = 4096;
    settings_done = 0;
    burst_left = 0;
    foreach (sent[i]) sent[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, then a small region that can be filled up.
    send(CMD_ALLOC, '0, 13'd1);
    send(CMD_ALLOC, '0, 13'd0);
    send(CMD_ALLOC, '0, 13'd4096);
    send(CMD_ALLOC, '0, 13'h1FFF);
    send(CMD_FREE, '0, 13'd3);
    send(CMD_FREE, addr_of_page(0), 13'd0);
    send(CMD_MARK, '0, 13'd0);
    send(CMD_MARK, addr_of_page(0) + 12'hABC, 13'd0);
    send(CMD_MARK, addr_of_page(4095), 13'd0);
    send(CMD_MARK, addr_of_page(4096), 13'd0);
    send(CMD_MARK, '1, 13'd0);
    send(CMD_FREE, addr_of_page(4094), 13'd5);
    send(CMD_FREE, addr_of_page(0), 13'd2);
    send(CMD_FREE, '1, 13'h1FFF);
    set_registers(64'h0000_0000_1000_0000, 13'd40, 13'd3);
    send(CMD_ALLOC, '0, 13'd37);
    send(CMD_ALLOC, '0, 13'd1);
    send(CMD_FREE, addr_of_page(5), 13'd1);
    send(CMD_FREE, addr_of_page(20), 13'd1);
    send(CMD_ALLOC, '0, 13'd2);
    send(CMD_MARK, addr_of_page(0) - 4096, 13'd0);
    send(CMD_FREE, addr_of_page(38), 13'd4);
    send(CMD_ALLOC, '0, 13'd1);

    // Random phases over several register settings, extremes among them.
    set_registers('0, 13'd4096, 13'd0);
    random_requests(100);
    set_registers(64'hFFFF_FFFF_FFF0_0000, 13'd64, 13'd8191);
    random_requests(80);
    set_registers({$urandom, $urandom}, CNT_W'($urandom_range(1, 300)),
                  CNT_W'($urandom_range(0, 20)));
    random_requests(130);
    set_registers('1, 13'd1, 13'd0);
    random_requests(40);
    // Sender waits here until every result has come back.
    drain();
    set_registers(64'h0000_7FFF_0000_0000, 13'd0, 13'd5);
    random_requests(40);
    set_registers({$urandom, 12'h000}, 13'h1FFF, 13'd100);
    random_requests(130);
    set_registers('0, CNT_W'($urandom_range(16, 128)), CNT_W'($urandom_range(0, 8)));
    random_requests(150);
    set_registers(64'h5555_AAAA_0000_0000, CNT_W'($urandom_range(2, 64)), 13'd1);
    random_requests(150);
    set_registers(64'h0000_0000_0000_1000, 13'd4096, 13'd4096);
    random_requests(110);

    drain();
    repeat (200) @(posedge clk);
    $display("Checked %0d results over %0d register settings.", results_seen,
             settings_done + 1);
    $display("Requests: %0d init, %0d alloc, %0d free, %0d mark.",
             sent[CMD_INIT], sent[CMD_ALLOC], sent[CMD_FREE], sent[CMD_MARK]);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
src/bpa_pkg.sv
src/bpa_ram.sv
src/bpa_run_finder.sv
src/bpa_word_update.sv
src/bitmap_page_allocator.sv
src/bpa_checker.sv
tb/bpa_checker.sv
tb/testbench.sv
